// ===== sv/sate_pkg.sv =====
package sate_pkg;

  localparam int CAPACITY   = 64;
  localparam int WORD_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int LEN_W      = $clog2(CAPACITY + 1);

  typedef logic signed [WORD_WIDTH-1:0] word_t;

  typedef enum logic [2:0] {
    CMD_INSERT     = 3'd0,
    CMD_REMOVE     = 3'd1,
    CMD_READ       = 3'd2,
    CMD_WRITE      = 3'd3,
    CMD_FIND_FIRST = 3'd4,
    CMD_FIND_LAST  = 3'd5,
    CMD_RESIZE     = 3'd6,
    CMD_ERASE      = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_LENGTH = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic             en;
    cmd_e             cmd;
    logic [LEN_W-1:0] idx;
    logic [LEN_W-1:0] nlen;
    logic [LEN_W-1:0] len;
    word_t            word;
  } cell_ctrl_t;

endpackage

// ===== sv/sate_cell.sv =====
module sate_cell import sate_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [LEN_W-1:0] pos_i,
  input  cell_ctrl_t       ctrl_i,
  input  word_t            left_i,
  input  word_t            right_i,
  output word_t            data_o,
  output logic             match_o
);

  word_t data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.en) begin
      unique case (ctrl_i.cmd)
        CMD_INSERT: begin
          if (pos_i > ctrl_i.idx) begin
            data_d = left_i;
          end else if (pos_i == ctrl_i.idx) begin
            data_d = ctrl_i.word;
          end
        end
        CMD_REMOVE: begin
          if (pos_i >= ctrl_i.idx) begin
            data_d = right_i;
          end
        end
        CMD_WRITE: begin
          if (pos_i == ctrl_i.idx) begin
            data_d = ctrl_i.word;
          end
        end
        CMD_RESIZE: begin
          if (pos_i >= ctrl_i.nlen) begin
            data_d = '0;
          end
        end
        CMD_ERASE: begin
          data_d = '0;
        end
        default: begin
          data_d = data_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else begin
      data_q <= data_d;
    end
  end

  assign data_o  = data_q;
  assign match_o = (data_q == ctrl_i.word) && (pos_i < ctrl_i.len);

endmodule

// ===== sv/sate_find.sv =====
module sate_find import sate_pkg::*; (
  input  logic [CAPACITY-1:0] match_i,
  input  logic                last_i,
  output logic                found_o,
  output logic [IDX_W-1:0]    index_o
);

  logic [CAPACITY-1:0] vec;
  logic [CAPACITY-1:0] iso;
  logic [IDX_W-1:0]    enc;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      vec[i] = last_i ? match_i[CAPACITY-1-i] : match_i[i];
    end
  end

  // Two's complement trick keeps only the lowest set bit.
  assign iso = vec & (~vec + 1'b1);

  always_comb begin
    enc = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (iso[i]) begin
        enc = enc | IDX_W'(i);
      end
    end
  end

  assign found_o = |match_i;
  assign index_o = !found_o ? '0 : (last_i ? IDX_W'(CAPACITY - 1) - enc : enc);

endmodule

// ===== sv/shifting_array_table_engine.sv =====
// Ordered array of signed words held in a chain of cells, one word per cell.
// Every command acts on the whole chain at once: all cells shift, load, clear or
// compare at the same clock edge, so a new item is accepted on every cycle
// and busy stays low. The result of an item is shown with done_o high in
// the cycle right after the item was accepted, for that one cycle only; the
// receiver cannot stall and must take it in that cycle. The lowest or highest
// match of a find is picked from the registered compare vector in that result
// cycle. After reset the array is empty.
module shifting_array_table_engine import sate_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command_i,
  input  logic [6:0]  index_i,
  input  logic [31:0] value_i,
  input  logic [6:0]  resize_len_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [31:0] read_value_o,
  output logic        found_o,
  output logic [5:0]  found_index_o,
  output logic [6:0]  current_length_o
);

  cmd_e             cmd;
  logic             accept;
  logic [LEN_W-1:0] idx;
  logic [LEN_W-1:0] nlen;
  word_t            word;
  status_e          status_d, status_q;
  logic [LEN_W-1:0] len_d, len_q;
  cell_ctrl_t       ctrl;

  word_t               cell_data [CAPACITY];
  logic [CAPACITY-1:0] cell_match;
  logic [CAPACITY-1:0] cell_sel;
  word_t               rd_d, rd_q;
  logic [CAPACITY-1:0] match_q;
  logic                done_q, find_q, last_q;
  logic                fnd;
  logic [IDX_W-1:0]    fidx;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign cmd    = cmd_e'(command_i);
  assign idx    = LEN_W'(index_i);
  assign nlen   = LEN_W'(resize_len_i);
  assign word   = WORD_WIDTH'($signed(value_i));

  always_comb begin
    status_d = ST_OK;
    len_d    = len_q;
    unique case (cmd) inside
      CMD_INSERT: begin
        if (idx > len_q) begin
          status_d = ST_RANGE;
        end else if (len_q >= LEN_W'(CAPACITY)) begin
          status_d = ST_FULL;
        end else begin
          len_d = len_q + 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (idx >= len_q) begin
          status_d = ST_RANGE;
        end else begin
          len_d = len_q - 1'b1;
        end
      end
      CMD_READ, CMD_WRITE: begin
        if (idx >= len_q) begin
          status_d = ST_RANGE;
        end
      end
      CMD_RESIZE: begin
        if (nlen == '0 || nlen > LEN_W'(CAPACITY)) begin
          status_d = ST_LENGTH;
        end else begin
          len_d = nlen;
        end
      end
      CMD_ERASE: begin
        len_d = '0;
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  assign ctrl.en   = accept && (status_d == ST_OK);
  assign ctrl.cmd  = cmd;
  assign ctrl.idx  = idx;
  assign ctrl.nlen = nlen;
  assign ctrl.len  = len_q;
  assign ctrl.word = word;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    word_t left_w, right_w;
    if (k == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[k+1];
    end
    sate_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .pos_i   (LEN_W'(k)),
      .ctrl_i  (ctrl),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[k]),
      .match_o (cell_match[k])
    );
    assign cell_sel[k] = (idx == LEN_W'(k));
  end

  always_comb begin
    rd_d = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cell_sel[i]) begin
        rd_d = rd_d | cell_data[i];
      end
    end
    if (cmd != CMD_READ || status_d != ST_OK) begin
      rd_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q   <= 1'b0;
      len_q    <= '0;
      status_q <= ST_OK;
      rd_q     <= '0;
      match_q  <= '0;
      find_q   <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        len_q    <= len_d;
        status_q <= status_d;
        rd_q     <= rd_d;
        find_q   <= (cmd == CMD_FIND_FIRST) || (cmd == CMD_FIND_LAST);
        last_q   <= (cmd == CMD_FIND_LAST);
        match_q  <= ((cmd == CMD_FIND_FIRST) || (cmd == CMD_FIND_LAST)) ? cell_match : '0;
      end
    end
  end

  sate_find u_find (
    .match_i (match_q),
    .last_i  (last_q),
    .found_o (fnd),
    .index_o (fidx)
  );

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign read_value_o     = 32'(rd_q);
  assign found_o          = done_q && find_q && fnd;
  assign found_index_o    = 6'(fidx);
  assign current_length_o = 7'(len_q);

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(CAPACITY))
    else $error("length exceeds capacity");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("accepted item gave no result");

  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_FULL) |-> (len_q == LEN_W'(CAPACITY)))
    else $error("full reported on an array that is not full");

  a_tail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q < LEN_W'(CAPACITY)) |-> (cell_data[CAPACITY-1] == '0))
    else $error("entry past the length is not zero");

  a_found_find: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_o |-> (done_o && status_o == ST_OK))
    else $error("match flagged outside a find result");

endmodule
